// ===== hdl/html_tag_strip_entity_decode_defines.svh =====
// Assertion macros shared by the tag stripper and entity decoder RTL.
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_DEFINES_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hts_pkg.sv =====
// Shared types, character codes and lookup functions for the tag stripper.
`default_nettype none
package hts_pkg;

  localparam int MAX_ENTITY_DEF = 32;
  localparam int NUM_NAMES      = 13;
  localparam logic [20:0] CP_LIMIT = 21'h110000;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_XL   = 8'h78;
  localparam logic [7:0] CH_XU   = 8'h58;

  typedef struct packed {
    logic       open;
    logic       store;
    logic [7:0] c;
  } ent_ctl_t;

  typedef struct packed {
    logic        is_hash;
    logic        named;
    logic [3:0]  name_idx;
    logic [20:0] value;
  } ent_stat_t;

  typedef struct packed {
    logic       emit;
    logic       fin;
    logic       eoi;
    logic [7:0] data;
  } emit_req_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } seq_t;

  function automatic logic [2:0] name_len(input logic [3:0] k);
    logic [2:0] l;
    unique case (k)
      4'd0:                      l = 3'd3;
      4'd1, 4'd2:                l = 3'd2;
      4'd3, 4'd4, 4'd5:          l = 3'd4;
      4'd6, 4'd7, 4'd8, 4'd9,
      4'd10, 4'd11:              l = 3'd5;
      4'd12:                     l = 3'd6;
      default:                   l = 3'd0;
    endcase
    return l;
  endfunction

  // Character p of name k; the string is right-justified, first char highest.
  function automatic logic [7:0] name_char(input logic [3:0] k, input logic [2:0] p);
    logic [47:0] nm;
    logic [2:0]  l;
    logic [2:0]  sel;
    unique case (k)
      4'd0:    nm = "amp";
      4'd1:    nm = "lt";
      4'd2:    nm = "gt";
      4'd3:    nm = "quot";
      4'd4:    nm = "apos";
      4'd5:    nm = "nbsp";
      4'd6:    nm = "mdash";
      4'd7:    nm = "ndash";
      4'd8:    nm = "lsquo";
      4'd9:    nm = "rsquo";
      4'd10:   nm = "ldquo";
      4'd11:   nm = "rdquo";
      4'd12:   nm = "hellip";
      default: nm = '0;
    endcase
    l   = name_len(k);
    sel = l - 3'd1 - p;
    if (p < l) return nm[{sel, 3'b000} +: 8];
    return 8'h00;
  endfunction

  function automatic seq_t name_bytes(input logic [3:0] k);
    seq_t s;
    s.b   = '0;
    s.len = 3'd3;
    s.b[0] = 8'hE2;
    s.b[1] = 8'h80;
    unique case (k)
      4'd0:    begin s.b[0] = 8'h26; s.len = 3'd1; end
      4'd1:    begin s.b[0] = 8'h3C; s.len = 3'd1; end
      4'd2:    begin s.b[0] = 8'h3E; s.len = 3'd1; end
      4'd3:    begin s.b[0] = 8'h22; s.len = 3'd1; end
      4'd4:    begin s.b[0] = 8'h27; s.len = 3'd1; end
      4'd5:    begin s.b[0] = 8'h20; s.len = 3'd1; end
      4'd6:    s.b[2] = 8'h94;
      4'd7:    s.b[2] = 8'h93;
      4'd8:    s.b[2] = 8'h98;
      4'd9:    s.b[2] = 8'h99;
      4'd10:   s.b[2] = 8'h9C;
      4'd11:   s.b[2] = 8'h9D;
      default: s.b[2] = 8'hA6;
    endcase
    if (s.len == 3'd1) s.b[1] = 8'h00;
    return s;
  endfunction

  function automatic seq_t utf8_bytes(input logic [20:0] cp);
    seq_t s;
    s.b = '0;
    if (cp < 21'h80) begin
      s.b[0] = cp[7:0];
      s.len  = 3'd1;
    end else if (cp < 21'h800) begin
      s.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      s.b[1] = 8'h80 | {2'b00, cp[5:0]};
      s.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      s.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
      s.b[1] = 8'h80 | {2'b00, cp[11:6]};
      s.b[2] = 8'h80 | {2'b00, cp[5:0]};
      s.len  = 3'd3;
    end else begin
      s.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
      s.b[1] = 8'h80 | {2'b00, cp[17:12]};
      s.b[2] = 8'h80 | {2'b00, cp[11:6]};
      s.b[3] = 8'h80 | {2'b00, cp[5:0]};
      s.len  = 3'd4;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hts_ent_track.sv =====
// Entity tracker: name match mask and numeric accumulator with one shared digit unit.
`default_nettype none
module hts_ent_track #(
  parameter int MAX_ENTITY = hts_pkg::MAX_ENTITY_DEF
) (
  input  wire logic                           clk,
  input  wire hts_pkg::ent_ctl_t              ctl,
  input  wire logic [$clog2(MAX_ENTITY+1)-1:0] pos,
  output hts_pkg::ent_stat_t                  stat
);
  localparam int PW = $clog2(MAX_ENTITY + 1);

  logic [hts_pkg::NUM_NAMES-1:0] mask;
  logic        hash;
  logic        hex;
  logic        stop;
  logic [20:0] value;

  logic        dv;
  logic [3:0]  d;
  logic [24:0] prod;
  logic [24:0] sum;
  logic [20:0] value_next;

  // Shared multiply-accumulate: value * base + digit, saturated.
  always_comb begin
    dv = 1'b0;
    d  = 4'd0;
    if (ctl.c >= 8'h30 && ctl.c <= 8'h39) begin
      dv = 1'b1;
      d  = 4'(ctl.c - 8'h30);
    end else if (hex && ctl.c >= 8'h61 && ctl.c <= 8'h66) begin
      dv = 1'b1;
      d  = 4'(ctl.c - 8'h57);
    end else if (hex && ctl.c >= 8'h41 && ctl.c <= 8'h46) begin
      dv = 1'b1;
      d  = 4'(ctl.c - 8'h37);
    end
    prod = hex ? {value, 4'b0000} : ({1'b0, value, 3'b000} + {3'b000, value, 1'b0});
    sum  = prod + {21'd0, d};
    value_next = (sum >= {4'd0, hts_pkg::CP_LIMIT}) ? hts_pkg::CP_LIMIT : sum[20:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.open) begin
      mask  <= '1;
      hash  <= 1'b0;
      hex   <= 1'b0;
      stop  <= 1'b0;
      value <= '0;
    end else if (ctl.store) begin
      for (int k = 0; k < hts_pkg::NUM_NAMES; k++) begin
        if (pos < PW'(6)) begin
          mask[k] <= mask[k] & (ctl.c == hts_pkg::name_char(4'(k), pos[2:0]));
        end
      end
      if (pos == '0) begin
        hash <= (ctl.c == hts_pkg::CH_HASH);
      end else if (hash) begin
        if (pos == PW'(1) && (ctl.c == hts_pkg::CH_XL || ctl.c == hts_pkg::CH_XU)) begin
          hex <= 1'b1;
        end else if (!stop) begin
          if (dv) value <= value_next;
          else    stop  <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    stat.is_hash  = hash;
    stat.value    = value;
    stat.named    = 1'b0;
    stat.name_idx = 4'd0;
    for (int k = 0; k < hts_pkg::NUM_NAMES; k++) begin
      if (mask[k] && PW'(hts_pkg::name_len(4'(k))) == pos) begin
        stat.named    = 1'b1;
        stat.name_idx = 4'(k);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hts_out_stage.sv =====
// Output stage: holds the newest result back until its run_last flag is known.
`default_nettype none
module hts_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire hts_pkg::emit_req_t   req,
  output logic                      can_push,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,  // out_byte
  output logic [1:0]                m_tuser,  // [0] byte_valid, [1] end_of_text
  output logic                      m_tlast   // run_last
);
  logic       held_v;
  logic [7:0] held;

  assign can_push = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      held_v   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (can_push) begin
        if (req.emit) begin
          held   <= req.data;
          held_v <= 1'b1;
          if (held_v) begin
            m_tvalid <= 1'b1;
            m_tdata  <= held;
            m_tuser  <= 2'b01;
            m_tlast  <= 1'b0;
          end
        end else if (req.fin) begin
          held_v <= 1'b0;
          if (held_v) begin
            m_tvalid <= 1'b1;
            m_tdata  <= held;
            m_tuser  <= {req.eoi, 1'b1};
            m_tlast  <= 1'b1;
          end else if (req.eoi) begin
            // no byte in this run: send a bare end marker
            m_tvalid <= 1'b1;
            m_tdata  <= 8'h00;
            m_tuser  <= 2'b10;
            m_tlast  <= 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/html_tag_strip_entity_decode.sv =====
// Flow: an input byte is taken only in idle, so a new byte waits until the last one is
//   fully processed by the sequencer that walks the replay stack and entity buffer one byte
//   per step; a decoded entity emits its extra output bytes in turn, an unknown name replays
//   its buffered bytes, a push-back writes bytes onto the replay stack for reprocessing,
//   and output stalls hold the sequencer.
// Reset: synchronous, clears tag/entity flags, counters, stack pointer and output valid;
//   the entity buffer and replay stack contents are not cleared.
`default_nettype none
`include "html_tag_strip_entity_decode_defines.svh"
module html_tag_strip_entity_decode #(
  parameter int MAX_ENTITY = hts_pkg::MAX_ENTITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // in_byte
  input  wire logic       s_tlast,   // end_of_input
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic [1:0]      m_tuser,   // [0] byte_valid, [1] end_of_text
  output logic            m_tlast    // run_last
);
  localparam int NW     = $clog2(MAX_ENTITY + 1);
  localparam int EAW    = $clog2(MAX_ENTITY);
  localparam int SAW    = $clog2(2 * MAX_ENTITY + 4);
  localparam int SD     = 2 ** SAW;
  localparam int OUTCAP = MAX_ENTITY + 2;
  localparam int RW     = $clog2(OUTCAP + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HANDLE, S_NEXT, S_SEQ, S_PRD, S_PEM, S_RQX, S_RRD, S_RWR, S_FIN
  } state_t;

  typedef enum logic [1:0] { AFT_NONE, AFT_PASS, AFT_REQ } aft_t;

  state_t         state, state_next;
  aft_t           after, after_next;
  logic           in_tag, in_tag_next;
  logic           in_ent, in_ent_next;
  logic [NW-1:0]  cnt, cnt_next;
  logic [NW-1:0]  n, n_next;
  logic [EAW-1:0] idx, idx_next;
  logic           eoi, eoi_next;
  logic [7:0]     cur, cur_next;
  logic           from_q, from_q_next;
  logic [SAW:0]   sp, sp_next;
  hts_pkg::seq_t  seq, seq_next;
  logic [2:0]     seq_k, seq_k_next;
  logic           rq_x_v, rq_x_v_next;
  logic [7:0]     rq_x, rq_x_next;
  logic [RW-1:0]  res_n, res_n_next;

  logic [7:0] smem [SD];
  logic [7:0] ebuf [MAX_ENTITY];
  logic [7:0] s_rd;
  logic [7:0] eb_rd;
  logic       s_we;
  logic [7:0] s_wdata;
  logic       e_we;
  logic [SAW:0] sp_m1;

  hts_pkg::ent_ctl_t  ent_ctl;
  hts_pkg::ent_stat_t ent_stat;
  hts_pkg::emit_req_t req;
  logic               can_push;
  logic [7:0]         c;
  logic               cap_ok;

  hts_ent_track #(.MAX_ENTITY(MAX_ENTITY)) u_track (
    .clk  (clk),
    .ctl  (ent_ctl),
    .pos  (cnt),
    .stat (ent_stat)
  );

  hts_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .can_push (can_push),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  assign s_tready = (state == S_IDLE);
  assign sp_m1    = sp - 1'b1;
  assign c        = from_q ? s_rd : cur;
  assign cap_ok   = (res_n < RW'(OUTCAP));

  // Replay stack and entity buffer
  always_ff @(posedge clk) begin
    if (s_we) smem[sp[SAW-1:0]] <= s_wdata;
    s_rd <= smem[sp_m1[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (e_we) ebuf[cnt[EAW-1:0]] <= c;
    eb_rd <= ebuf[idx];
  end

  always_comb begin
    state_next  = state;
    after_next  = after;
    in_tag_next = in_tag;
    in_ent_next = in_ent;
    cnt_next    = cnt;
    n_next      = n;
    idx_next    = idx;
    eoi_next    = eoi;
    cur_next    = cur;
    from_q_next = from_q;
    sp_next     = sp;
    seq_next    = seq;
    seq_k_next  = seq_k;
    rq_x_v_next = rq_x_v;
    rq_x_next   = rq_x;
    res_n_next  = res_n;
    s_we        = 1'b0;
    s_wdata     = rq_x;
    e_we        = 1'b0;
    ent_ctl     = '0;
    ent_ctl.c   = c;
    req         = '0;
    req.eoi     = eoi;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cur_next    = s_tdata;
          eoi_next    = s_tlast;
          from_q_next = 1'b0;
          res_n_next  = '0;
          state_next  = S_HANDLE;
        end
      end

      S_HANDLE: begin
        if (from_q) sp_next = sp_m1;
        state_next = S_NEXT;
        seq_k_next = 3'd0;
        if (in_ent) begin
          if (c == hts_pkg::CH_SEMI) begin
            in_ent_next = 1'b0;
            cnt_next    = '0;
            n_next      = cnt;
            if (ent_stat.is_hash) begin
              if (ent_stat.value == '0) begin
                // zero value: literal '&', then reprocess the buffer and ';'
                seq_next     = '0;
                seq_next.b[0] = hts_pkg::CH_AMP;
                seq_next.len = 3'd1;
                after_next   = AFT_REQ;
                rq_x_v_next  = 1'b1;
                rq_x_next    = hts_pkg::CH_SEMI;
                state_next   = S_SEQ;
              end else if (ent_stat.value < hts_pkg::CP_LIMIT) begin
                seq_next   = hts_pkg::utf8_bytes(ent_stat.value);
                after_next = AFT_NONE;
                state_next = S_SEQ;
              end
            end else if (ent_stat.named) begin
              seq_next   = hts_pkg::name_bytes(ent_stat.name_idx);
              after_next = AFT_NONE;
              state_next = S_SEQ;
            end else begin
              seq_next      = '0;
              seq_next.b[0] = hts_pkg::CH_AMP;
              seq_next.len  = 3'd1;
              after_next    = AFT_PASS;
              state_next    = S_SEQ;
            end
          end else if (cnt == NW'(MAX_ENTITY)) begin
            // buffer full: literal '&', then reprocess the buffer and this byte
            in_ent_next   = 1'b0;
            cnt_next      = '0;
            n_next        = cnt;
            seq_next      = '0;
            seq_next.b[0] = hts_pkg::CH_AMP;
            seq_next.len  = 3'd1;
            after_next    = AFT_REQ;
            rq_x_v_next   = 1'b1;
            rq_x_next     = c;
            state_next    = S_SEQ;
          end else begin
            e_we          = 1'b1;
            ent_ctl.store = 1'b1;
            cnt_next      = cnt + 1'b1;
          end
        end else if (in_tag) begin
          if (c == hts_pkg::CH_GT) in_tag_next = 1'b0;
        end else if (c == hts_pkg::CH_LT) begin
          in_tag_next = 1'b1;
        end else if (c == hts_pkg::CH_AMP) begin
          in_ent_next  = 1'b1;
          cnt_next     = '0;
          ent_ctl.open = 1'b1;
        end else begin
          seq_next      = '0;
          seq_next.b[0] = c;
          seq_next.len  = 3'd1;
          after_next    = AFT_NONE;
          state_next    = S_SEQ;
        end
      end

      S_NEXT: begin
        if (sp != '0) begin
          from_q_next = 1'b1;
          state_next  = S_HANDLE;
        end else if (eoi && in_ent) begin
          // open entity at end of text: literal '&', then reprocess the buffer
          in_ent_next   = 1'b0;
          cnt_next      = '0;
          n_next        = cnt;
          seq_next      = '0;
          seq_next.b[0] = hts_pkg::CH_AMP;
          seq_next.len  = 3'd1;
          seq_k_next    = 3'd0;
          after_next    = AFT_REQ;
          rq_x_v_next   = 1'b0;
          state_next    = S_SEQ;
        end else begin
          state_next = S_FIN;
        end
      end

      S_SEQ: begin
        if (seq_k == seq.len) begin
          unique case (after)
            AFT_NONE: state_next = S_NEXT;
            AFT_PASS: begin
              if (n == '0) begin
                seq_next      = '0;
                seq_next.b[0] = hts_pkg::CH_SEMI;
                seq_next.len  = 3'd1;
                seq_k_next    = 3'd0;
                after_next    = AFT_NONE;
              end else begin
                idx_next   = '0;
                state_next = S_PRD;
              end
            end
            AFT_REQ:  state_next = S_RQX;
            default:  state_next = S_NEXT;
          endcase
        end else if (!cap_ok || can_push) begin
          if (cap_ok) begin
            req.emit   = 1'b1;
            req.data   = seq.b[seq_k[1:0]];
            res_n_next = res_n + 1'b1;
          end
          seq_k_next = seq_k + 3'd1;
        end
      end

      S_PRD: state_next = S_PEM;

      S_PEM: begin
        if (!cap_ok || can_push) begin
          if (cap_ok) begin
            req.emit   = 1'b1;
            req.data   = eb_rd;
            res_n_next = res_n + 1'b1;
          end
          if (NW'(idx) + 1'b1 == n) begin
            seq_next      = '0;
            seq_next.b[0] = hts_pkg::CH_SEMI;
            seq_next.len  = 3'd1;
            seq_k_next    = 3'd0;
            after_next    = AFT_NONE;
            state_next    = S_SEQ;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_PRD;
          end
        end
      end

      S_RQX: begin
        // push in reverse so the first buffered byte ends on top
        if (rq_x_v) begin
          s_we    = 1'b1;
          s_wdata = rq_x;
          sp_next = sp + 1'b1;
        end
        if (n == '0) begin
          state_next = S_NEXT;
        end else begin
          idx_next   = EAW'(n - 1'b1);
          state_next = S_RRD;
        end
      end

      S_RRD: state_next = S_RWR;

      S_RWR: begin
        s_we    = 1'b1;
        s_wdata = eb_rd;
        sp_next = sp + 1'b1;
        if (idx == '0) begin
          state_next = S_NEXT;
        end else begin
          idx_next   = idx - 1'b1;
          state_next = S_RRD;
        end
      end

      S_FIN: begin
        if (can_push) begin
          req.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_tag <= 1'b0;
      in_ent <= 1'b0;
      cnt    <= '0;
      sp     <= '0;
      res_n  <= '0;
      from_q <= 1'b0;
      eoi    <= 1'b0;
    end else begin
      state  <= state_next;
      in_tag <= in_tag_next;
      in_ent <= in_ent_next;
      cnt    <= cnt_next;
      sp     <= sp_next;
      res_n  <= res_n_next;
      from_q <= from_q_next;
      eoi    <= eoi_next;
    end
    after  <= after_next;
    n      <= n_next;
    idx    <= idx_next;
    cur    <= cur_next;
    seq    <= seq_next;
    seq_k  <= seq_k_next;
    rq_x_v <= rq_x_v_next;
    rq_x   <= rq_x_next;
  end

  `HTS_ASSERT_NOW(a_idle_stack_empty, clk, rst, s_tready, sp == '0, "replay stack not empty at idle")
  `HTS_ASSERT_NOW(a_res_cap, clk, rst, 1'b1, res_n <= RW'(OUTCAP), "result count over cap")
  `HTS_ASSERT_NOW(a_push_room, clk, rst, req.emit || req.fin, can_push, "push without room")
  `HTS_ASSERT_NEXT(a_fin_to_idle, clk, rst, state == S_FIN && can_push, state == S_IDLE, "fin stuck")

endmodule
`default_nettype wire

// ===== verif/html_tag_strip_entity_decode_checker.sv =====
// Scoreboard for the tag stripper: predicts decoded text and checks the output stream.
module html_tag_strip_entity_decode_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic [1:0] m_tuser,
  input  logic       m_tlast,
  output int         errors,
  output int         outstanding
);
  localparam int ENT_MAX  = hts_pkg::MAX_ENTITY_DEF;
  localparam int OUT_CAP  = ENT_MAX + 2;
  localparam int PEND_CAP = 2 * ENT_MAX + 4;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       eot;
    logic       run_last;
  } text_out_t;

  text_out_t   expected_text[$];
  text_out_t   step_text[$];
  logic [7:0]  pending_bytes[$];
  logic [7:0]  ent_buf[ENT_MAX];
  int          ent_cnt;
  logic        in_tag, in_ent;
  string       ent_names[hts_pkg::NUM_NAMES] = '{"amp", "lt", "gt", "quot", "apos", "nbsp",
                                                 "mdash", "ndash", "lsquo", "rsquo", "ldquo",
                                                 "rdquo", "hellip"};
  logic [7:0]  ent_tail[hts_pkg::NUM_NAMES] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h20,
                                               8'h94, 8'h93, 8'h98, 8'h99, 8'h9C, 8'h9D,
                                               8'hA6};

  function automatic void put_byte(logic [7:0] b);
    text_out_t t;
    t.data = b; t.valid = 1'b1; t.eot = 1'b0; t.run_last = 1'b0;
    if (step_text.size() < OUT_CAP) step_text.push_back(t);
  endfunction

  function automatic void push_front_bytes(logic [7:0] src[$]);
    pending_bytes = {src, pending_bytes};
    if (pending_bytes.size() > PEND_CAP) pending_bytes = pending_bytes[0:PEND_CAP-1];
  endfunction

  function automatic int digit_of(logic [7:0] c, int base);
    if (c >= "0" && c <= "9") return c - "0";
    if (base == 16 && c >= "a" && c <= "f") return c - "a" + 10;
    if (base == 16 && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void resolve_ref();
    logic [7:0] b[$];
    int         n, base, pos, d;
    logic [31:0] cp;
    bit         hit;
    n = ent_cnt;
    for (int i = 0; i < n; i++) b.push_back(ent_buf[i]);
    in_ent = 1'b0;
    ent_cnt = 0;
    if (n >= 1 && b[0] == hts_pkg::CH_HASH) begin
      base = 10; pos = 1; cp = 0;
      if (n >= 2 && (b[1] == hts_pkg::CH_XL || b[1] == hts_pkg::CH_XU)) begin
        base = 16; pos = 2;
      end
      for (int i = pos; i < n; i++) begin
        d = digit_of(b[i], base);
        if (d < 0) break;
        cp = cp * base + d;
        if (cp >= hts_pkg::CP_LIMIT) cp = hts_pkg::CP_LIMIT;
      end
      if (cp == 0) begin
        // zero value: literal ampersand, then reread the body as text
        put_byte(hts_pkg::CH_AMP);
        b.push_back(hts_pkg::CH_SEMI);
        push_front_bytes(b);
      end else if (cp < 32'h80) begin
        put_byte(cp[7:0]);
      end else if (cp < 32'h800) begin
        put_byte(8'hC0 | cp[10:6]);
        put_byte(8'h80 | cp[5:0]);
      end else if (cp < 32'h10000) begin
        put_byte(8'hE0 | cp[15:12]);
        put_byte(8'h80 | cp[11:6]);
        put_byte(8'h80 | cp[5:0]);
      end else if (cp < hts_pkg::CP_LIMIT) begin
        put_byte(8'hF0 | cp[20:18]);
        put_byte(8'h80 | cp[17:12]);
        put_byte(8'h80 | cp[11:6]);
        put_byte(8'h80 | cp[5:0]);
      end
      return;
    end
    for (int k = 0; k < hts_pkg::NUM_NAMES; k++) begin
      hit = (ent_names[k].len() == n);
      for (int i = 0; i < n && hit; i++) if (ent_names[k][i] != b[i]) hit = 0;
      if (hit) begin
        if (k < 6) put_byte(ent_tail[k]);
        else begin
          put_byte(8'hE2); put_byte(8'h80); put_byte(ent_tail[k]);
        end
        return;
      end
    end
    put_byte(hts_pkg::CH_AMP);
    for (int i = 0; i < n; i++) put_byte(b[i]);
    put_byte(hts_pkg::CH_SEMI);
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic [7:0] b[$];
    if (in_ent) begin
      if (c == hts_pkg::CH_SEMI) resolve_ref();
      else if (ent_cnt >= ENT_MAX) begin
        for (int i = 0; i < ENT_MAX; i++) b.push_back(ent_buf[i]);
        b.push_back(c);
        in_ent = 1'b0;
        ent_cnt = 0;
        put_byte(hts_pkg::CH_AMP);
        push_front_bytes(b);
      end else begin
        ent_buf[ent_cnt] = c;
        ent_cnt++;
      end
    end else if (in_tag) begin
      if (c == hts_pkg::CH_GT) in_tag = 1'b0;
    end else if (c == hts_pkg::CH_LT) in_tag = 1'b1;
    else if (c == hts_pkg::CH_AMP) begin
      in_ent = 1'b1;
      ent_cnt = 0;
    end else put_byte(c);
  endfunction

  function automatic void predict_text(logic [7:0] c, logic eoi);
    logic [7:0] b[$];
    text_out_t  t;
    step_text.delete();
    pending_bytes = {c};
    forever begin
      while (pending_bytes.size() > 0) scan_byte(pending_bytes.pop_front());
      if (!eoi || !in_ent) break;
      // open entity at end of text: flush it as literal text
      b.delete();
      for (int i = 0; i < ent_cnt; i++) b.push_back(ent_buf[i]);
      in_ent = 1'b0;
      ent_cnt = 0;
      put_byte(hts_pkg::CH_AMP);
      push_front_bytes(b);
    end
    if (eoi && step_text.size() == 0) begin
      t.data = 8'h00; t.valid = 1'b0; t.eot = 1'b0; t.run_last = 1'b0;
      step_text.push_back(t);
    end
    if (step_text.size() > 0) begin
      step_text[$].run_last = 1'b1;
      if (eoi) step_text[$].eot = 1'b1;
    end
    foreach (step_text[i]) expected_text.push_back(step_text[i]);
  endfunction

  always @(posedge clk) begin
    text_out_t e;
    int        bad;
    bad = 0;
    if (rst) begin
      in_tag = 1'b0;
      in_ent = 1'b0;
      ent_cnt = 0;
      expected_text.delete();
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_text(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected output transfer: out_byte=%h", m_tdata);
          bad++;
        end else begin
          e = expected_text.pop_front();
          if (m_tdata !== e.data) begin
            $error("out_byte: expected %h, got %h", e.data, m_tdata);
            bad++;
          end
          if (m_tuser[0] !== e.valid) begin
            $error("byte_valid: expected %b, got %b", e.valid, m_tuser[0]);
            bad++;
          end
          if (m_tuser[1] !== e.eot) begin
            $error("end_of_text: expected %b, got %b", e.eot, m_tuser[1]);
            bad++;
          end
          if (m_tlast !== e.run_last) begin
            $error("run_last: expected %b, got %b", e.run_last, m_tlast);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
    outstanding <= expected_text.size();
  end
endmodule

// ===== verif/html_tag_strip_entity_decode_test.sv =====
// Top of the tag stripper bench: clock, reset, text stimulus and verdict.
module html_tag_strip_entity_decode_test;
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // in_byte
  logic       s_tlast = 1'b0;    // end_of_input
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // out_byte
  logic [1:0] m_tuser;           // [0] byte_valid, [1] end_of_text
  logic       m_tlast;           // run_last
  int         errors, outstanding;
  int         bytes_sent = 0;
  bit         long_hold = 0;

  string ent_pool[16] = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "mdash", "ndash",
                          "lsquo", "rsquo", "ldquo", "rdquo", "hellip", "foo", "AMP", ""};

  always #5 clk = ~clk;

  html_tag_strip_entity_decode u_dut (.*);

  html_tag_strip_entity_decode_checker u_chk (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, bit idle);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    gap = idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // last byte of a text carries end_of_input when requested
  task automatic send_text(string s, bit eoi_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], eoi_at_end && i == s.len() - 1, $urandom_range(0, 3) != 0);
  endtask

  function automatic string random_word(int lo, int hi);
    string w;
    w = "";
    repeat ($urandom_range(lo, hi)) w = {w, string'(byte'($urandom_range(8'h61, 8'h7A)))};
    return w;
  endfunction

  function automatic string random_segment();
    string s;
    int    k;
    k = $urandom_range(0, 99);
    if (k < 20) s = random_word(1, 6);
    else if (k < 32) s = {"<", random_word(0, 5), ">"};
    else if (k < 55) s = {"&", ent_pool[$urandom_range(0, 15)], ";"};
    else if (k < 65) s = $sformatf("&#%0d;", $urandom_range(1, 1200000));
    else if (k < 75) s = $sformatf("&#%s%0h;", $urandom_range(0, 1) ? "x" : "X",
                                   $urandom_range(1, 32'h11FFFF));
    else if (k < 79) s = {"&#", string'($urandom_range(0, 1) ? "x0" : "00"), random_word(0, 3),
                          string'($urandom_range(0, 1) ? "<q>" : "&lt"), ";"};
    else if (k < 83) s = {"&", random_word(31, 36), string'($urandom_range(0, 1) ? ";" : " ")};
    else if (k < 87) s = $sformatf("&#9%0d;", $urandom_range(10000000, 99999999));
    else begin
      s = "";
      repeat ($urandom_range(1, 6)) s = {s, string'(byte'($urandom_range(1, 255)))};
    end
    return s;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else m_tready <= 1'b1;
    end
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    string seg;
    bit    held = 0, drained = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_text("<i>x&lt;&#0;", 0);
    send_text("&#x110000;&hellip;&zz;", 0);
    send_text("&#65", 1);
    send_text("<b", 1);
    send_byte(8'h00, 1'b0, 0);
    send_byte(8'hFF, 1'b1, 0);
    while (bytes_sent < 470) begin
      if (!held && bytes_sent > 150) begin
        held = 1;
        long_hold = 1;
      end
      if (!drained && bytes_sent > 320) begin
        drained = 1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
      end
      seg = random_segment();
      send_text(seg, $urandom_range(0, 9) == 0);
    end
    send_byte(8'h2E, 1'b1, 0);
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (150) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== html_tag_strip_entity_decode.f =====
+incdir+hdl
hdl/hts_pkg.sv
hdl/hts_ent_track.sv
hdl/hts_out_stage.sv
hdl/html_tag_strip_entity_decode.sv
verif/html_tag_strip_entity_decode_checker.sv
verif/html_tag_strip_entity_decode_test.sv
